// File: hdl/bpq_pkg.sv
// Package with the shared constants, types and codes of the bucketed priority queue.
`timescale 1ns / 1ps
package bpq_pkg;
   localparam int PRIO_LEVELS = 8;
   localparam int LEVEL_DEPTH = 64;
   localparam int ID_BITS     = 16;
   localparam int LV_BITS     = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
   localparam int POS_BITS    = $clog2(LEVEL_DEPTH);
   localparam int CNT_BITS    = $clog2(LEVEL_DEPTH + 1);
   localparam int ADDR_BITS   = LV_BITS + POS_BITS;
   localparam int MEM_DEPTH   = PRIO_LEVELS * LEVEL_DEPTH;
   localparam int TOT_BITS    = 10;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP        = 3'd2,
      OP_REM_KEEP   = 3'd3,
      OP_REM_SWAP   = 3'd4,
      OP_CLEAR      = 3'd5,
      OP_RSVD6      = 3'd6,
      OP_RSVD7      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_POP_SCAN, S_SHIFT_RD, S_SHIFT_WR,
      S_FIND_RD, S_FIND_CMP, S_COMPACT_RD, S_COMPACT_WR, S_SWAP_RD, S_SWAP_WR,
      S_RESP
   } state_type;
endpackage

// File: hdl/bucketed_priority_queue_core.sv
// Top level of the bucketed priority queue: control sequencer around one entry RAM.
//
//   channel | direction | words
//   req_*   | in        | tdata = {level, item_id, op}, one operation per word
//   rsp_*   | out       | tdata = {total_count, status, popped_id}, one per request
//
// Push back, clear and the unused codes finish straight from decode. A pop scans the
// levels one by one from level 0, passing each empty one, and reads the last entry of the
// first level that holds one. Push front moves each entry of the level up by one with a
// read state and a write state. A remove compares each entry in turn and, keeping order,
// moves each later entry down with a read and a write. The single RAM port is why entries
// move one at a time. Reset is synchronous and clears the state and the counters only;
// the RAM contents are never used before being written. One request is in work at a time;
// req_tready is low from acceptance until the response word has been taken, so a stalled
// receiver adds its stall cycles to the item.
`timescale 1ns / 1ps
module bucketed_priority_queue_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // op[2:0], item_id[18:3], level[21:19], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // popped_id[15:0], status[17:16], total_count[27:18]
);
   import bpq_pkg::*;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [2:0]           lv_ff, lv_in;
   logic [LV_BITS-1:0]   lvi_ff, lvi_in;     // working level
   logic [CNT_BITS-1:0]  idx_ff, idx_in;     // working position
   logic [CNT_BITS-1:0]  cnt_ff [PRIO_LEVELS];
   logic [CNT_BITS-1:0]  cnt_in [PRIO_LEVELS];
   logic [TOT_BITS-1:0]  total_ff, total_in;
   logic [15:0]          pop_ff, pop_in;
   status_type           st_ff, st_in;

   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_addr;
   logic [ID_BITS-1:0]    mem_wd, mem_rd;
   logic [CNT_BITS-1:0]   cur_cnt;
   logic                  lv_ok;

   bpq_ram #(.WIDTH(ID_BITS), .DEPTH(MEM_DEPTH)) u_store (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr), .wr_data(mem_wd), .rd_data(mem_rd)
   );

   assign cur_cnt = cnt_ff[lvi_ff];
   assign lv_ok   = ({29'd0, lv_ff} < PRIO_LEVELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         for (int i = 0; i < PRIO_LEVELS; i++) cnt_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         for (int i = 0; i < PRIO_LEVELS; i++) cnt_ff[i] <= cnt_in[i];
      end
      op_ff <= op_in; id_ff <= id_in; lv_ff <= lv_in; lvi_ff <= lvi_in;
      idx_ff <= idx_in; pop_ff <= pop_in; st_ff <= st_in;
   end

   // Next state and datapath.
   always_comb begin
      state_in = state_ff;
      op_in = op_ff; id_in = id_ff; lv_in = lv_ff; lvi_in = lvi_ff; idx_in = idx_ff;
      pop_in = pop_ff; st_in = st_ff; total_in = total_ff;
      for (int i = 0; i < PRIO_LEVELS; i++) cnt_in[i] = cnt_ff[i];
      mem_we = 1'b0; mem_wd = id_ff;
      mem_addr = {lvi_ff, idx_ff[POS_BITS-1:0]};
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in  = op_type'(req_tdata[2:0]);
               id_in  = req_tdata[3 +: ID_BITS];
               lv_in  = req_tdata[21:19];
               lvi_in = LV_BITS'(req_tdata[21:19]);
               pop_in = '0;
               st_in  = ST_DONE;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority case (op_ff)
               OP_PUSH_BACK, OP_PUSH_FRONT: begin
                  if (!lv_ok || cur_cnt >= CNT_BITS'(LEVEL_DEPTH)) begin
                     st_in = ST_FULL;
                     state_in = S_RESP;
                  end else if (op_ff == OP_PUSH_BACK) begin
                     mem_we = 1'b1;
                     mem_addr = {lvi_ff, cur_cnt[POS_BITS-1:0]};
                     cnt_in[lvi_ff] = cur_cnt + 1'b1;
                     total_in = total_ff + 1'b1;
                     state_in = S_RESP;
                  end else begin
                     idx_in = cur_cnt;   // shift from back to front
                     state_in = S_SHIFT_RD;
                  end
               end
               OP_POP: begin
                  lvi_in = '0;
                  state_in = S_POP_SCAN;
               end
               OP_REM_KEEP, OP_REM_SWAP: begin
                  if (!lv_ok) begin
                     st_in = ST_EMPTY; state_in = S_RESP;
                  end else begin
                     idx_in = '0; state_in = S_FIND_RD;
                  end
               end
               OP_CLEAR: begin
                  for (int i = 0; i < PRIO_LEVELS; i++) cnt_in[i] = '0;
                  total_in = '0;
                  state_in = S_RESP;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_POP_SCAN: begin
            if (cur_cnt != '0) begin
               idx_in = cur_cnt - 1'b1;
               mem_addr = {lvi_ff, idx_in[POS_BITS-1:0]};
               cnt_in[lvi_ff] = cur_cnt - 1'b1;
               total_in = total_ff - 1'b1;
               state_in = S_SWAP_RD;   // reuse: capture popped word next cycle
            end else if ({{(32-LV_BITS){1'b0}}, lvi_ff} == PRIO_LEVELS - 1) begin
               st_in = ST_EMPTY; state_in = S_RESP;
            end else begin
               lvi_in = lvi_ff + 1'b1;
            end
         end
         S_SHIFT_RD: begin
            if (idx_ff == '0) begin
               mem_we = 1'b1;
               cnt_in[lvi_ff] = cur_cnt + 1'b1;
               total_in = total_ff + 1'b1;
               state_in = S_RESP;
            end else begin
               mem_addr = {lvi_ff, POS_BITS'(idx_ff - 1'b1)};
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            mem_we = 1'b1; mem_wd = mem_rd;
            idx_in = idx_ff - 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_FIND_RD: begin
            if (idx_ff >= cur_cnt) begin
               st_in = ST_EMPTY; state_in = S_RESP;
            end else begin
               state_in = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (mem_rd == id_ff) begin
               state_in = (op_ff == OP_REM_KEEP) ? S_COMPACT_RD : S_SWAP_RD;
               if (op_ff == OP_REM_SWAP)
                  mem_addr = {lvi_ff, POS_BITS'(cur_cnt - 1'b1)};
               else
                  mem_addr = {lvi_ff, POS_BITS'(idx_ff + 1'b1)};
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_FIND_RD;
            end
         end
         S_COMPACT_RD: begin
            // mem_rd holds entry idx+1 when it exists
            if (idx_ff + 1'b1 >= cur_cnt) begin
               cnt_in[lvi_ff] = cur_cnt - 1'b1;
               total_in = total_ff - 1'b1;
               state_in = S_RESP;
            end else begin
               mem_we = 1'b1; mem_wd = mem_rd;
               idx_in = idx_ff + 1'b1;
               state_in = S_COMPACT_WR;
            end
         end
         S_COMPACT_WR: begin
            mem_addr = {lvi_ff, POS_BITS'(idx_ff + 1'b1)};
            state_in = S_COMPACT_RD;
         end
         S_SWAP_RD: begin
            if (op_ff == OP_POP) begin
               pop_in = 16'(mem_rd);
               state_in = S_RESP;
            end else begin
               mem_we = 1'b1; mem_wd = mem_rd;
               cnt_in[lvi_ff] = cur_cnt - 1'b1;
               total_in = total_ff - 1'b1;
               state_in = S_SWAP_WR;
            end
         end
         S_SWAP_WR: state_in = S_RESP;
         S_RESP: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = (state_ff == S_RESP);
      rsp_tdata  = {4'd0, total_ff, st_ff, pop_ff};
   end
endmodule

// File: hdl/bpq_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
module bpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// File: hdl/bpq_checker.sv
// Port-level checker for the bucketed priority queue core, with its bind.
`timescale 1ns / 1ps
module bpq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import bpq_pkg::*;
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("busy and idle at once");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped while stalled");
   a_pop0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:16] != ST_DONE |-> rsp_tdata[15:0] == 16'd0)
      else $error("failed operation returned an identifier");
   a_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[27:18] <= 10'(MEM_DEPTH))
      else $error("total beyond capacity");
endmodule

bind bucketed_priority_queue_core bpq_checker u_bpq_checker (.*);

// File: sim/bucketed_priority_queue_core_checker.sv
// Checker for the bucketed priority queue: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module bucketed_priority_queue_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   import bpq_pkg::*;

   typedef struct packed {
      logic [9:0]  total;
      status_type  status;
      logic [15:0] popped;
   } reply_type;

   logic [ID_BITS-1:0] lists [PRIO_LEVELS][LEVEL_DEPTH];
   int                 fill [PRIO_LEVELS];
   int                 held;
   reply_type          replies_due [$];

   assign pending = replies_due.size();

   function automatic reply_type apply_op(op_type op, logic [15:0] id, logic [2:0] lv);
      reply_type r;
      int        pos;
      r.popped = '0;
      r.status = ST_DONE;
      pos = -1;
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (lv >= PRIO_LEVELS || fill[lv] >= LEVEL_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (op == OP_PUSH_BACK) begin
                  lists[lv][fill[lv]] = id;
               end else begin
                  for (int i = fill[lv]; i > 0; i--) lists[lv][i] = lists[lv][i-1];
                  lists[lv][0] = id;
               end
               fill[lv]++;
               held++;
            end
         end
         OP_POP: begin
            r.status = ST_EMPTY;
            for (int i = 0; i < PRIO_LEVELS; i++) begin
               if (fill[i] != 0) begin
                  fill[i]--;
                  r.popped = lists[i][fill[i]];
                  held--;
                  r.status = ST_DONE;
                  break;
               end
            end
         end
         OP_REM_KEEP, OP_REM_SWAP: begin
            if (lv < PRIO_LEVELS) begin
               for (int i = 0; i < fill[lv]; i++) begin
                  if (lists[lv][i] == id) begin
                     pos = i;
                     break;
                  end
               end
            end
            if (pos < 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (op == OP_REM_KEEP) begin
                  for (int i = pos; i + 1 < fill[lv]; i++) lists[lv][i] = lists[lv][i+1];
               end else begin
                  lists[lv][pos] = lists[lv][fill[lv]-1];
               end
               fill[lv]--;
               held--;
            end
         end
         OP_CLEAR: begin
            foreach (fill[i]) fill[i] = 0;
            held = 0;
         end
         default: ;
      endcase
      r.total = held[9:0];
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want, got;
      if (reset) begin
         foreach (fill[i]) fill[i] = 0;
         held = 0;
         fail_count <= 0;
         replies_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[27:0];
            if (replies_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = replies_due.pop_front();
               if (got.popped !== want.popped || got.status !== want.status ||
                   got.total !== want.total) begin
                  $display("%0t: mismatch, expected id %h st %0d tot %0d,",
                           $time, want.popped, want.status, want.total,
                           " actual id %h st %0d tot %0d",
                           got.popped, got.status, got.total);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            replies_due = {replies_due, apply_op(op_type'(req_tdata[2:0]),
                                                 req_tdata[18:3], req_tdata[21:19])};
      end
   end
endmodule

// File: sim/bucketed_priority_queue_core_test.sv
// Testbench top for the bucketed priority queue: stimulus, reset, watchdog and verdict.
`timescale 1ns / 1ps
module bucketed_priority_queue_core_test;
   import bpq_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   int          fail_count, pending;
   bit          calm;
   int          quiet_cycles = 0;
   logic [15:0] recent_ids [$];

   always #5 clock = ~clock;

   bucketed_priority_queue_core u_dut (.*);

   bucketed_priority_queue_core_checker u_check (.*);

   // The receiver stalls about 13 percent of the time, except during the calm stretch.
   always @(posedge clock)
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 13);

   // Watchdog: fails the run when neither channel moves; a remove holds the block longest,
   // and receiver stalls add to that.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("** bucketed_priority_queue_core: FAILED **");
         $finish;
      end
   end

   // Sends one word and waits for its acceptance; idles first at random.
   task automatic send_word(op_type op, logic [15:0] id, logic [2:0] lv);
      while (!calm && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, lv, id, op};
      do @(posedge clock); while (!req_tready);
      if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
         recent_ids = {recent_ids, id};
         if (recent_ids.size() > 64) void'(recent_ids.pop_front());
      end
   endtask

   // Picks an identifier that was probably pushed, so removes mostly hit.
   function automatic logic [15:0] known_id();
      if (recent_ids.size() == 0 || $urandom_range(9) == 0)
         return 16'($urandom_range(65535));
      return recent_ids[$urandom_range(recent_ids.size() - 1)];
   endfunction

   initial begin
      op_type op;
      int     pick;
      calm = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty pop, misses, extremes, every op and both full cases.
      send_word(OP_POP, 16'h0000, 3'd0);
      send_word(OP_REM_KEEP, 16'h1234, 3'd7);
      send_word(OP_PUSH_BACK, 16'hFFFF, 3'd7);
      send_word(OP_PUSH_FRONT, 16'h0000, 3'd7);
      send_word(OP_PUSH_BACK, 16'hA5A5, 3'd0);
      send_word(OP_PUSH_FRONT, 16'h5A5A, 3'd0);
      send_word(OP_REM_SWAP, 16'h5A5A, 3'd0);
      send_word(OP_REM_KEEP, 16'hFFFF, 3'd7);
      send_word(OP_REM_SWAP, 16'hBEEF, 3'd3);
      send_word(OP_RSVD6, 16'hFFFF, 3'd7);
      send_word(OP_RSVD7, 16'h0000, 3'd0);
      send_word(OP_POP, 16'h0000, 3'd0);
      send_word(OP_POP, 16'h0000, 3'd0);
      send_word(OP_POP, 16'h0000, 3'd0);
      // Fill level 4 to the brim and push twice more; the extra pushes are dropped.
      for (int i = 0; i < LEVEL_DEPTH + 2; i++)
         send_word(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, 16'(i * 997), 3'd4);
      send_word(OP_REM_KEEP, 16'(2 * 997), 3'd4);
      send_word(OP_REM_SWAP, 16'(3 * 997), 3'd4);
      send_word(OP_CLEAR, 16'hFFFF, 3'd7);
      send_word(OP_POP, 16'h0000, 3'd0);

      // Random part: mostly pushes and removes of known identifiers, with rare clears.
      for (int n = 0; n < 1400; n++) begin
         calm = (n >= 600 && n < 800);
         pick = $urandom_range(99);
         if (pick < 40) op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         else if (pick < 60) op = OP_POP;
         else if (pick < 75) op = OP_REM_KEEP;
         else if (pick < 90) op = OP_REM_SWAP;
         else if (pick < 92) op = OP_CLEAR;
         else op = op_type'(3'($urandom_range(7)));
         send_word(op, (op == OP_REM_KEEP || op == OP_REM_SWAP) ? known_id()
                                                                 : 16'($urandom_range(65535)),
                   3'($urandom_range(7)));
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("** bucketed_priority_queue_core: PASSED **");
      else
         $display("** bucketed_priority_queue_core: FAILED **");
      $finish;
   end
endmodule
